>>> rtl/ssit_pkg.sv
// ----------------------------------------------------------------------------
// ssit_pkg
// Shared types and constants of the symbol sequence interning trie.
// ----------------------------------------------------------------------------
`default_nettype none

package ssit_pkg;

	// Channel payload widths
	localparam int unsigned SYM_W      = 16;
	localparam int unsigned ID_OUT_W   = 10;

	// Default sizes
	localparam int unsigned DEF_TABLE_SLOTS = 1024;
	localparam int unsigned DEF_MAX_IDS     = 1024;
	localparam int unsigned DEF_SYMBOL_BITS = 16;
	localparam int unsigned DEF_MAX_PROBES  = 16;

	// Fibonacci hash multiplier, split into 32-bit halves
	localparam logic [31:0] HASH_MUL_HI = 32'h9E3779B9;
	localparam logic [31:0] HASH_MUL_LO = 32'h7F4A7C15;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH0,
		ST_HASH1,
		ST_HASH2,
		ST_MOD0,
		ST_MOD1,
		ST_MOD2,
		ST_PROBE,
		ST_CHECK,
		ST_END,
		ST_MARK
	} ssit_state_t;

endpackage

`default_nettype wire

>>> rtl/ssit_sym_if.sv
// ----------------------------------------------------------------------------
// ssit_sym_if
// Symbol channel: one symbol per transfer, with an end-of-sequence flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssit_sym_if import ssit_pkg::*;;
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             last_of_word;

	modport source (output valid, output symbol, output last_of_word, input ready);
	modport sink   (input valid, input symbol, input last_of_word, output ready);
endinterface

`default_nettype wire

>>> rtl/ssit_id_if.sv
// ----------------------------------------------------------------------------
// ssit_id_if
// Result channel: interned sequence id with hit and overflow flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssit_id_if import ssit_pkg::*;;
	logic                valid;
	logic                ready;
	logic [ID_OUT_W-1:0] sequence_id;
	logic                seen_before;
	logic                table_full;

	modport source (output valid, output sequence_id, output seen_before,
		output table_full, input ready);
	modport sink   (input valid, input sequence_id, input seen_before,
		input table_full, output ready);
endinterface

`default_nettype wire

>>> rtl/symbol_sequence_interning_trie.sv
// ----------------------------------------------------------------------------
// symbol_sequence_interning_trie
// Interns symbol sequences as ids through a lazily built hashed trie.
// ----------------------------------------------------------------------------
// Flow: an accepted symbol passes the hash multiply states (ST_HASH0..ST_HASH2),
//   the modulo states (ST_MOD0..ST_MOD2), a probe and a check of the one-read-port
//   slot memory for each slot probed (up to min(MAX_PROBES, TABLE_SLOTS) slots) and
//   the end state before the next symbol can be taken. The last symbol adds the
//   resolved-mark update and holds while the previous id word waits; symbols after
//   a failure in their sequence go straight to the end state. One symbol at a time.
// Reset: after arst_n releases, max(TABLE_SLOTS, MAX_IDS) cycles clear both
//   memories, one entry per cycle, while ready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module symbol_sequence_interning_trie import ssit_pkg::*; #(
	parameter int unsigned TABLE_SLOTS = DEF_TABLE_SLOTS,
	parameter int unsigned MAX_IDS     = DEF_MAX_IDS,
	parameter int unsigned SYMBOL_BITS = DEF_SYMBOL_BITS,
	parameter int unsigned MAX_PROBES  = DEF_MAX_PROBES
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ssit_sym_if.sink    symbols,
	ssit_id_if.source   ids
);

	localparam int unsigned SLOT_BITS   = $clog2(TABLE_SLOTS);
	localparam int unsigned ID_BITS     = $clog2(MAX_IDS);
	localparam int unsigned NFREE_BITS  = $clog2(MAX_IDS + 1);
	localparam int unsigned KEY_BITS    = ID_BITS + SYMBOL_BITS;
	localparam int unsigned ENTRY_BITS  = 1 + KEY_BITS + ID_BITS;
	localparam int unsigned PROBE_LIMIT = (MAX_PROBES < TABLE_SLOTS) ? MAX_PROBES : TABLE_SLOTS;
	localparam int unsigned PROBE_BITS  = $clog2(PROBE_LIMIT + 1);
	localparam int unsigned CLR_DEPTH   = (TABLE_SLOTS > MAX_IDS) ? TABLE_SLOTS : MAX_IDS;
	localparam int unsigned CLR_BITS    = $clog2(CLR_DEPTH);
	localparam int unsigned RED_BITS    = $clog2(2 * TABLE_SLOTS);
	localparam logic [31:0] RECIP       = 32'((64'd1 << 32) / TABLE_SLOTS);

	// Memories
	logic [ENTRY_BITS-1:0] slot_mem [TABLE_SLOTS];
	logic                  mark_mem [MAX_IDS];
	logic [ENTRY_BITS-1:0] slot_rd_q;
	logic                  mark_rd_q;

	// Control state
	ssit_state_t           state_q, state_d;
	logic [CLR_BITS-1:0]   clr_idx_q;
	logic [ID_BITS-1:0]    walk_q;
	logic                  failed_q;
	logic [NFREE_BITS-1:0] next_free_q;
	logic                  out_valid_q;

	// Datapath registers
	logic [KEY_BITS-1:0]   key_q;
	logic                  last_q;
	logic [63:0]           m0_q;
	logic [31:0]           acc_q;
	logic [31:0]           h_q;
	logic [31:0]           qe_q;
	logic [RED_BITS-1:0]   r_q;
	logic [SLOT_BITS-1:0]  pos_q;
	logic [PROBE_BITS-1:0] probes_q;
	logic [ID_OUT_W-1:0]   out_id_q;
	logic                  out_seen_q;
	logic                  out_full_q;

	// Memory controls
	logic                  slot_we;
	logic [SLOT_BITS-1:0]  slot_waddr;
	logic [ENTRY_BITS-1:0] slot_wdata;
	logic                  mark_we;
	logic [ID_BITS-1:0]    mark_waddr;
	logic                  mark_wdata;

	// Datapath
	logic [63:0]           key_ext;
	logic [63:0]           mul0;
	logic [31:0]           mul1;
	logic [31:0]           mul2;
	logic [63:0]           qe_full;
	logic [47:0]           qts;
	logic [RED_BITS-1:0]   r_next;
	logic [SLOT_BITS-1:0]  pos_hashed;
	logic [SLOT_BITS-1:0]  pos_inc;
	logic                  rd_valid;
	logic [KEY_BITS-1:0]   rd_key;
	logic [ID_BITS-1:0]    rd_target;
	logic                  ids_full;
	logic                  chk_hit;
	logic                  chk_alloc;
	logic                  chk_fail;
	logic                  out_free;
	logic                  out_load;
	logic                  accept;
	logic                  clr_done;

	assign key_ext    = 64'(key_q);
	assign mul0       = 64'(key_ext[31:0]) * 64'(HASH_MUL_LO);
	assign mul1       = 32'(key_ext[31:0] * HASH_MUL_HI);
	assign mul2       = 32'(key_ext[63:32] * HASH_MUL_LO);
	assign qe_full    = 64'(h_q) * 64'(RECIP);
	assign qts        = 48'(qe_q) * 48'(TABLE_SLOTS);
	// Reciprocal estimate is at most one short, so the remainder stays below 2*TABLE_SLOTS
	assign r_next     = RED_BITS'(h_q - qts[31:0]);
	assign pos_hashed = (r_q >= RED_BITS'(TABLE_SLOTS)) ?
		SLOT_BITS'(r_q - RED_BITS'(TABLE_SLOTS)) : SLOT_BITS'(r_q);
	assign pos_inc    = (pos_q == SLOT_BITS'(TABLE_SLOTS - 1)) ? '0 : pos_q + 1'b1;

	assign rd_valid   = slot_rd_q[ENTRY_BITS-1];
	assign rd_key     = slot_rd_q[ENTRY_BITS-2:ID_BITS];
	assign rd_target  = slot_rd_q[ID_BITS-1:0];
	assign ids_full   = (next_free_q >= NFREE_BITS'(MAX_IDS));
	assign chk_hit    = rd_valid && (rd_key == key_q);
	assign chk_alloc  = !rd_valid && !ids_full;
	assign chk_fail   = (!rd_valid && ids_full) ||
		(rd_valid && !chk_hit &&
		 (PROBE_BITS'(probes_q + 1'b1) == PROBE_BITS'(PROBE_LIMIT)));

	assign out_free   = !out_valid_q || ids.ready;
	// load the result register: a resolved id, or a failed sequence ending
	assign out_load   = (state_q == ST_MARK) ||
		(state_q == ST_END && last_q && out_free && failed_q);
	assign accept     = symbols.valid && symbols.ready;
	assign clr_done   = (clr_idx_q == CLR_BITS'(CLR_DEPTH - 1));

	assign symbols.ready   = (state_q == ST_IDLE);
	assign ids.valid       = out_valid_q;
	assign ids.sequence_id = out_id_q;
	assign ids.seen_before = out_seen_q;
	assign ids.table_full  = out_full_q;

	// Next state and memory write controls
	always_comb begin
		state_d    = state_q;
		slot_we    = 1'b0;
		slot_waddr = pos_q;
		slot_wdata = {1'b1, key_q, ID_BITS'(next_free_q)};
		mark_we    = 1'b0;
		mark_waddr = walk_q;
		mark_wdata = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				slot_we    = ((CLR_BITS+1)'(clr_idx_q) < (CLR_BITS+1)'(TABLE_SLOTS));
				slot_waddr = SLOT_BITS'(clr_idx_q);
				slot_wdata = '0;
				mark_we    = ((CLR_BITS+1)'(clr_idx_q) < (CLR_BITS+1)'(MAX_IDS));
				mark_waddr = ID_BITS'(clr_idx_q);
				mark_wdata = 1'b0;
				if (clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = failed_q ? ST_END : ST_HASH0;
				end
			end
			ST_HASH0: state_d = ST_HASH1;
			ST_HASH1: state_d = ST_HASH2;
			ST_HASH2: state_d = ST_MOD0;
			ST_MOD0:  state_d = ST_MOD1;
			ST_MOD1:  state_d = ST_MOD2;
			ST_MOD2:  state_d = ST_PROBE;
			ST_PROBE: state_d = ST_CHECK;
			ST_CHECK: begin
				slot_we = chk_alloc;
				if (chk_alloc || chk_hit || chk_fail) begin
					state_d = ST_END;
				end else begin
					state_d = ST_PROBE;
				end
			end
			ST_END: begin
				priority if (!last_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					state_d = failed_q ? ST_IDLE : ST_MARK;
				end
			end
			ST_MARK: begin
				mark_we = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Memories: one write port, registered read
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		slot_rd_q <= slot_mem[pos_q];
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_waddr] <= mark_wdata;
		end
		mark_rd_q <= mark_mem[walk_q];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q   <= '0;
			walk_q      <= '0;
			failed_q    <= 1'b0;
			next_free_q <= NFREE_BITS'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (ids.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (!clr_done) begin
						clr_idx_q <= clr_idx_q + 1'b1;
					end
				end
				ST_CHECK: begin
					priority if (chk_hit) begin
						walk_q <= rd_target;
					end else if (chk_alloc) begin
						walk_q      <= ID_BITS'(next_free_q);
						next_free_q <= next_free_q + 1'b1;
					end else if (chk_fail) begin
						failed_q <= 1'b1;
					end
				end
				ST_END: begin
					// a failed sequence reports straight away and starts over
					if (last_q && out_free && failed_q) begin
						walk_q      <= '0;
						failed_q    <= 1'b0;
					end
				end
				ST_MARK: begin
					walk_q      <= '0;
					failed_q    <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					key_q  <= {walk_q, SYMBOL_BITS'(symbols.symbol)};
					last_q <= symbols.last_of_word;
				end
			end
			ST_HASH0: m0_q  <= mul0;
			ST_HASH1: acc_q <= m0_q[63:32] + mul1;
			ST_HASH2: h_q   <= acc_q + mul2;
			ST_MOD0:  qe_q  <= qe_full[63:32];
			ST_MOD1:  r_q   <= r_next;
			ST_MOD2: begin
				pos_q    <= pos_hashed;
				probes_q <= '0;
			end
			ST_CHECK: begin
				// advance to the next slot on a collision
				pos_q    <= pos_inc;
				probes_q <= probes_q + 1'b1;
			end
			ST_END: begin
				if (last_q && out_free && failed_q) begin
					out_id_q   <= '0;
					out_seen_q <= 1'b0;
					out_full_q <= 1'b1;
				end
			end
			ST_MARK: begin
				out_id_q   <= ID_OUT_W'(walk_q);
				out_seen_q <= mark_rd_q;
				out_full_q <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Checks
	a_nfree_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= NFREE_BITS'(MAX_IDS))
		else $error("id allocator ran past the id space");

	a_alloc_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && chk_alloc) |=> next_free_q == $past(next_free_q) + 1'b1)
		else $error("allocation did not advance the free id");

	a_full_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_full_q) |-> (out_id_q == '0 && !out_seen_q))
		else $error("failed sequence carries an id");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_MARK || $past(state_q) == ST_END))
		else $error("result word raised outside the end of a sequence");

endmodule

`default_nettype wire
